@@ design/matrix_vector_transform_4x4_defines.svh @@
// assertion macros for the matrix vector transform block
`ifndef MATRIX_VECTOR_TRANSFORM_4X4_DEFINES_SVH
`define MATRIX_VECTOR_TRANSFORM_4X4_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MVT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, sampled on clk, off during reset
`define MVT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ design/mvt_pkg.sv @@
// shared types and codes for the matrix vector transform block
`default_nettype none

package mvt_pkg;

	// input opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_XFORM = 1'b1;

	// dimension register
	localparam int unsigned DIM_W = 3;
	localparam logic [DIM_W-1:0] DIM_RESET = 3'd4;
	localparam logic [DIM_W-1:0] DIM_THREE = 3'd3;

	// register index decode (byte address bit 2)
	localparam logic REG_DIMENSION = 1'b0;

	// per-stage load enables for the lanes
	typedef struct packed {
		logic en1;
		logic en2;
	} pipe_ctl_t;

	// controls for the merging stage
	typedef struct packed {
		logic en3;
		logic three;
	} merge_ctl_t;

endpackage

`default_nettype wire

@@ design/mvt_in_if.sv @@
// input channel interface: load rows and vectors
`default_nettype none

interface mvt_in_if #(
	parameter int ELEMENT_BITS = 32
) ();
	logic                           valid;
	logic                           ready;
	logic                           opcode;
	logic [1:0]                     row_index;
	logic signed [ELEMENT_BITS-1:0] elem0;
	logic signed [ELEMENT_BITS-1:0] elem1;
	logic signed [ELEMENT_BITS-1:0] elem2;
	logic signed [ELEMENT_BITS-1:0] elem3;

	modport source (
		output valid, opcode, row_index, elem0, elem1, elem2, elem3,
		input  ready
	);
	modport sink (
		input  valid, opcode, row_index, elem0, elem1, elem2, elem3,
		output ready
	);
endinterface

`default_nettype wire

@@ design/mvt_out_if.sv @@
// output channel interface: transformed vectors
`default_nettype none

interface mvt_out_if #(
	parameter int ELEMENT_BITS = 32
) ();
	logic                           valid;
	logic                           ready;
	logic signed [ELEMENT_BITS-1:0] out0;
	logic signed [ELEMENT_BITS-1:0] out1;
	logic signed [ELEMENT_BITS-1:0] out2;
	logic signed [ELEMENT_BITS-1:0] out3;

	modport source (
		output valid, out0, out1, out2, out3,
		input  ready
	);
	modport sink (
		input  valid, out0, out1, out2, out3,
		output ready
	);
endinterface

`default_nettype wire

@@ design/matrix_vector_transform_4x4.sv @@
// top level: matrix store, config register, four lanes, merge and pipeline control
//
// channel   dir  handshake      payload
// items     in   valid/ready    opcode, row_index, elem0..elem3
// results   out  valid/ready    out0..out3
// apb       in   psel/penable   dimension register at byte address 0
//
// one word accepted per cycle while items ready is high; a load writes its
// matrix row at acceptance and yields nothing, a transform yields its result
// through the lane multiply stage, the lane sum stage and the merge output
// register
// reset clears the matrix to zero and sets the dimension to four
// a stalled output fills bubbles first; items ready drops only when all
// three stages hold words
`default_nettype none
`include "matrix_vector_transform_4x4_defines.svh"

module matrix_vector_transform_4x4 #(
	parameter int ELEMENT_BITS = 32,
	parameter int FRAC_BITS    = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	mvt_in_if.sink      items,
	mvt_out_if.source   results,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mvt_pkg::*;

	localparam int SUM_W = 2 * ELEMENT_BITS + 2;

	logic [DIM_W-1:0]               dim_q;
	logic signed [ELEMENT_BITS-1:0] mat_q [4][4];
	logic signed [ELEMENT_BITS-1:0] vec   [4];
	logic signed [SUM_W-1:0]        sum_s2 [4];
	logic signed [ELEMENT_BITS-1:0] out_q [4];
	logic                           v_s1, v_s2, out_valid_q;
	logic                           three_s1, three_s2;
	logic                           three_mode;
	logic                           en1, en2, en3;
	logic                           in_fire;
	logic                           cfg_wr;
	pipe_ctl_t                      lane_ctl;
	merge_ctl_t                     mrg_ctl;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_DIMENSION) ? {{(32-DIM_W){1'b0}}, dim_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_RESET;
		end else if (cfg_wr && paddr[2] == REG_DIMENSION) begin
			dim_q <= pwdata[DIM_W-1:0];
		end
	end

	assign three_mode = (dim_q == DIM_THREE);

	// pipeline enables: a stage moves when it is empty or its successor moves
	assign en3     = !out_valid_q || results.ready;
	assign en2     = !v_s2 || en3;
	assign en1     = !v_s1 || en2;
	assign in_fire = items.valid && items.ready;
	assign items.ready = en1;

	assign lane_ctl = '{en1: en1, en2: en2};
	assign mrg_ctl  = '{en3: en3, three: three_s2};

	// matrix store, one row written per load word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					mat_q[r][c] <= '0;
				end
			end
		end else if (in_fire && items.opcode == OP_LOAD) begin
			mat_q[items.row_index][0] <= items.elem0;
			mat_q[items.row_index][1] <= items.elem1;
			mat_q[items.row_index][2] <= items.elem2;
			mat_q[items.row_index][3] <= items.elem3;
		end
	end

	// stage valids and mode flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			three_s1    <= 1'b0;
			three_s2    <= 1'b0;
		end else begin
			if (en1) begin
				v_s1     <= in_fire && items.opcode == OP_XFORM;
				three_s1 <= three_mode;
			end
			if (en2) begin
				v_s2     <= v_s1;
				three_s2 <= three_s1;
			end
			if (en3) begin
				out_valid_q <= v_s2;
			end
		end
	end

	// vector into the lanes; fourth element dropped in 3x3 mode
	assign vec[0] = items.elem0;
	assign vec[1] = items.elem1;
	assign vec[2] = items.elem2;
	assign vec[3] = three_mode ? '0 : items.elem3;

	// one lane per matrix row
	for (genvar r = 0; r < 4; r++) begin : g_lane
		mvt_lane #(
			.ELEMENT_BITS(ELEMENT_BITS),
			.SUM_W       (SUM_W)
		) u_lane (
			.clk     (clk),
			.ctl     (lane_ctl),
			.row_elem(mat_q[r]),
			.vec_elem(vec),
			.sum_s2  (sum_s2[r])
		);
	end

	mvt_merge #(
		.ELEMENT_BITS(ELEMENT_BITS),
		.FRAC_BITS   (FRAC_BITS),
		.SUM_W       (SUM_W)
	) u_merge (
		.clk   (clk),
		.ctl   (mrg_ctl),
		.sum_s2(sum_s2),
		.out_q (out_q)
	);

	// result channel
	assign results.valid = out_valid_q;
	assign results.out0  = out_q[0];
	assign results.out1  = out_q[1];
	assign results.out2  = out_q[2];
	assign results.out3  = out_q[3];

	// checks
	`MVT_ASSERT_NEXT(a_load_no_word, in_fire && items.opcode == OP_LOAD, !v_s1)
	`MVT_ASSERT_NEXT(a_xform_enters, in_fire && items.opcode == OP_XFORM, v_s1)
	`MVT_ASSERT_IMPL(a_full_stall, v_s1 && v_s2 && out_valid_q && !results.ready, !items.ready)

endmodule

`default_nettype wire

@@ design/mvt_lane.sv @@
// one dot product lane: four multipliers, then a registered four-way sum
`default_nettype none

module mvt_lane #(
	parameter int ELEMENT_BITS = 32,
	parameter int SUM_W        = 2 * ELEMENT_BITS + 2
) (
	input  wire                           clk,
	input  wire mvt_pkg::pipe_ctl_t       ctl,
	input  wire logic signed [ELEMENT_BITS-1:0] row_elem [4],
	input  wire logic signed [ELEMENT_BITS-1:0] vec_elem [4],
	output logic signed [SUM_W-1:0]       sum_s2
);
	import mvt_pkg::*;

	localparam int PROD_W = 2 * ELEMENT_BITS;

	logic signed [PROD_W-1:0] prod_s1 [4];

	// stage 1: element products
	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[c] <= row_elem[c] * vec_elem[c];
			end
		end
	end

	// stage 2: exact sum of the four products
	always_ff @(posedge clk) begin
		if (ctl.en2) begin
			sum_s2 <= SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[1])
				+ SUM_W'(prod_s1[2]) + SUM_W'(prod_s1[3]);
		end
	end

endmodule

`default_nettype wire

@@ design/mvt_merge.sv @@
// merging stage: scale, saturate and register the four lane sums
`default_nettype none

module mvt_merge #(
	parameter int ELEMENT_BITS = 32,
	parameter int FRAC_BITS    = 16,
	parameter int SUM_W        = 2 * ELEMENT_BITS + 2
) (
	input  wire                           clk,
	input  wire mvt_pkg::merge_ctl_t      ctl,
	input  wire logic signed [SUM_W-1:0]  sum_s2 [4],
	output logic signed [ELEMENT_BITS-1:0] out_q [4]
);
	import mvt_pkg::*;

	localparam logic signed [ELEMENT_BITS-1:0] E_MAX = {1'b0, {(ELEMENT_BITS-1){1'b1}}};
	localparam logic signed [ELEMENT_BITS-1:0] E_MIN = {1'b1, {(ELEMENT_BITS-1){1'b0}}};

	logic signed [SUM_W-1:0]        shifted [4];
	logic signed [ELEMENT_BITS-1:0] sat     [4];
	logic [SUM_W-ELEMENT_BITS:0]    upper   [4];

	// arithmetic shift toward minus infinity, then clamp to the element range
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			shifted[k] = sum_s2[k] >>> FRAC_BITS;
			upper[k]   = shifted[k][SUM_W-1:ELEMENT_BITS-1];
			if ((&upper[k]) || !(|upper[k])) begin
				sat[k] = shifted[k][ELEMENT_BITS-1:0];
			end else if (shifted[k][SUM_W-1]) begin
				sat[k] = E_MIN;
			end else begin
				sat[k] = E_MAX;
			end
		end
	end

	// output register; fourth word forced to zero in 3x3 mode
	always_ff @(posedge clk) begin
		if (ctl.en3) begin
			out_q[0] <= sat[0];
			out_q[1] <= sat[1];
			out_q[2] <= sat[2];
			out_q[3] <= ctl.three ? '0 : sat[3];
		end
	end

endmodule

`default_nettype wire
